// File: hw/rtl/b2d_pkg.sv
// ----------------------------------------------------------------------------
// b2d_pkg
// Shared constants and types for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2d_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 20;
  localparam int BCD_W       = 4;
  localparam int CHAR_W      = 6;
  localparam int IN_DATA_W   = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((CHAR_W + 7) / 8) * 8;
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int DIG_CNT_W   = $clog2(MAX_DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
  localparam logic [BCD_W-1:0]  BCD_FIVE   = BCD_W'(5);
  localparam logic [BCD_W-1:0]  BCD_THREE  = BCD_W'(3);

  // operation applied to every cell of the chain in the same cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_MOVE
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_EMIT
  } seq_state_t;

  // sequencer to datapath control
  typedef struct packed {
    cell_op_t op;
    logic     serial_bit;
    logic     emit;
    logic     emit_last;
  } seq_ctrl_t;

endpackage

// File: hw/rtl/b2d_cell.sv
// ----------------------------------------------------------------------------
// b2d_cell
// One BCD digit of the conversion chain: shift-add-3 step, digit move, clear or hold.
// ----------------------------------------------------------------------------
module b2d_cell
  import b2d_pkg::*;
(
  input  logic             clk,
  input  cell_op_t         op,
  input  logic             carry_in,
  input  logic [BCD_W-1:0] digit_in,
  output logic             carry_out,
  output logic [BCD_W-1:0] digit
);

  logic [BCD_W-1:0] adj;
  logic [BCD_W-1:0] digit_next;

  // add 3 when the digit would overflow past 9 after doubling
  assign adj       = (digit >= BCD_FIVE) ? digit + BCD_THREE : digit;
  assign carry_out = adj[BCD_W-1];

  always_comb begin
    case (op)
      CELL_CLEAR:  digit_next = '0;
      CELL_DABBLE: digit_next = {adj[BCD_W-2:0], carry_in};
      CELL_MOVE:   digit_next = digit_in;
      default:     digit_next = digit;
    endcase
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

// File: hw/rtl/b2d_seq.sv
// ----------------------------------------------------------------------------
// b2d_seq
// Sequencer: feeds the number bit by bit into the chain, skips leading zero
// digits and paces the digit output.
// ----------------------------------------------------------------------------
module b2d_seq
  import b2d_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   in_ready,
  input  logic                   out_free,
  input  logic [BCD_W-1:0]       top_digit,
  output seq_ctrl_t              ctrl
);

  seq_state_t             state, state_next;
  logic [VALUE_WIDTH-1:0] shreg, shreg_next;
  logic [BIT_CNT_W-1:0]   bit_cnt, bit_cnt_next;
  logic [DIG_CNT_W-1:0]   rem_cnt, rem_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bit_cnt <= '0;
      rem_cnt <= '0;
    end else begin
      state   <= state_next;
      bit_cnt <= bit_cnt_next;
      rem_cnt <= rem_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    shreg <= shreg_next;
  end

  always_comb begin
    state_next      = state;
    shreg_next      = shreg;
    bit_cnt_next    = bit_cnt;
    rem_cnt_next    = rem_cnt;
    in_ready        = 1'b0;
    ctrl.op         = CELL_HOLD;
    ctrl.serial_bit = shreg[VALUE_WIDTH-1];
    ctrl.emit       = 1'b0;
    ctrl.emit_last  = (rem_cnt == DIG_CNT_W'(1));
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          shreg_next   = in_value;
          bit_cnt_next = BIT_CNT_W'(VALUE_WIDTH);
          ctrl.op      = CELL_CLEAR;
          state_next   = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        ctrl.op      = CELL_DABBLE;
        shreg_next   = {shreg[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_next = bit_cnt - BIT_CNT_W'(1);
        if (bit_cnt == BIT_CNT_W'(1)) begin
          rem_cnt_next = DIG_CNT_W'(MAX_DIGITS);
          state_next   = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros but always keep the final digit
        if (top_digit == '0 && rem_cnt != DIG_CNT_W'(1)) begin
          ctrl.op      = CELL_MOVE;
          rem_cnt_next = rem_cnt - DIG_CNT_W'(1);
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ctrl.emit    = 1'b1;
          ctrl.op      = CELL_MOVE;
          rem_cnt_next = rem_cnt - DIG_CNT_W'(1);
          if (rem_cnt == DIG_CNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned binary number to a stream of ASCII decimal digits.
// ----------------------------------------------------------------------------
// Each input transaction carries one unsigned number; the block returns its
// decimal digits as ASCII '0'..'9', most significant first, one per output
// transaction, with tlast on the final digit. Leading zeros are dropped and
// zero gives a single '0'. Conversion runs through a chain of MAX_DIGITS BCD
// cells, one shift-add-3 step per cell per cycle, fed one input bit a cycle.
// A number is taken and the chain cleared, then all VALUE_WIDTH bits are
// shifted in, the skipped leading zeros are dropped one at a time, the
// sequencer moves to its output state and sends a digit whenever the
// output register is free. Skipped and sent digits always add up to MAX_DIGITS.
// Only one number is in work at a time; the next is taken once the previous
// final digit sits in the output register.
module binary_to_decimal_ascii
  import b2d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // value
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // digit_char, zero padding
  output logic                  m_tlast
);

  seq_ctrl_t        ctrl;
  logic             out_free;
  logic [BCD_W-1:0] digits [MAX_DIGITS];
  logic             carry  [MAX_DIGITS];
  logic [CHAR_W-1:0] char_reg;

  assign out_free = !m_tvalid || m_tready;

  b2d_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_value  (s_tdata[VALUE_WIDTH-1:0]),
    .in_ready  (s_tready),
    .out_free  (out_free),
    .top_digit (digits[MAX_DIGITS-1]),
    .ctrl      (ctrl)
  );

  // carry[i] enters cell i; cell 0 takes the serial input bit
  assign carry[0] = ctrl.serial_bit;

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_low
      b2d_cell u_cell (
        .clk       (clk),
        .op        (ctrl.op),
        .carry_in  (carry[0]),
        .digit_in  ('0),
        .carry_out (carry[1]),
        .digit     (digits[0])
      );
    end else if (i == MAX_DIGITS - 1) begin : g_top
      b2d_cell u_cell (
        .clk       (clk),
        .op        (ctrl.op),
        .carry_in  (carry[i]),
        .digit_in  (digits[i-1]),
        .carry_out (),
        .digit     (digits[i])
      );
    end else begin : g_mid
      b2d_cell u_cell (
        .clk       (clk),
        .op        (ctrl.op),
        .carry_in  (carry[i]),
        .digit_in  (digits[i-1]),
        .carry_out (carry[i+1]),
        .digit     (digits[i])
      );
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else if (ctrl.emit) begin
      m_tvalid <= 1'b1;
      m_tlast  <= ctrl.emit_last;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      char_reg <= ASCII_ZERO + CHAR_W'(digits[MAX_DIGITS-1]);
    end
  end

  assign m_tdata = OUT_DATA_W'(char_reg);

endmodule

// File: hw/rtl/b2d_checker.sv
// ----------------------------------------------------------------------------
// b2d_checker
// Port-level checks for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
module b2d_checker
  import b2d_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  // every emitted character is a decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[CHAR_W-1:0] >= ASCII_ZERO &&
                  m_tdata[CHAR_W-1:0] <= ASCII_ZERO + CHAR_W'(9)))
    else $error("output character is not a decimal digit");

  // a stalled output transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  // one number at a time: no input right after an accepted one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a conversion is running");

  // a new number is taken only when the previous run has ended
  a_run_ended: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !(m_tvalid && !m_tlast))
    else $error("input accepted in the middle of a digit run");

  // conversion takes time: no output right after an accepted number
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("digit appeared too early after input");

endmodule

bind binary_to_decimal_ascii b2d_checker u_b2d_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// File: test/binary_to_decimal_ascii_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_tb
// Stream test of the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
// Numbers go in on the slave side in bursts with random gaps. The scoreboard
// works out the decimal digits of every accepted number and compares each
// digit coming out of the master side, tdata and tlast, against the oldest
// one waiting. The receiver stalls on changing patterns, and once holds off
// long enough for the block to back up into its input.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_tb;
  import b2d_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RANDOM_ITEMS = 230;
  localparam int HOLD_CYCLES  = 800;
  localparam int DRAIN_CYCLES = 200;

  // receiver stall patterns
  localparam int RX_OPEN     = 0;
  localparam int RX_COIN     = 1;
  localparam int RX_SPARSE   = 2;
  localparam int RX_PERIODIC = 3;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } digit_item_t;

  class digit_scoreboard;
    digit_item_t expected_digits[$];
    int          mismatch_count = 0;

    // expand one number into its decimal digits, most significant first
    function void note_value(logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] rest;
      logic [3:0]             slot[MAX_DIGITS];
      int                     count;
      digit_item_t            item;
      rest  = value;
      count = 1;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        slot[i] = 4'(rest % 10);
        rest    = rest / 10;
        if (slot[i] != 0) count = i + 1;
      end
      for (int i = count - 1; i >= 0; i--) begin
        item.digit_char = ASCII_ZERO + CHAR_W'(slot[i]);
        item.last       = (i == 0);
        expected_digits.push_back(item);
      end
    endfunction

    function void check_digit(logic [OUT_DATA_W-1:0] data, logic last);
      digit_item_t want;
      if (expected_digits.size() == 0) begin
        $error("unexpected digit transaction: tdata %0h tlast %0b", data, last);
        mismatch_count++;
        return;
      end
      want = expected_digits.pop_front();
      if (data[CHAR_W-1:0] !== want.digit_char) begin
        $error("digit_char mismatch: expected %0d actual %0d", want.digit_char,
               data[CHAR_W-1:0]);
        mismatch_count++;
      end
      if (data[OUT_DATA_W-1:CHAR_W] !== '0) begin
        $error("padding mismatch: expected 0 actual %0h", data[OUT_DATA_W-1:CHAR_W]);
        mismatch_count++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %0b actual %0b", want.last, last);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return expected_digits.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // value
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // digit_char, zero padding
  logic                  m_tlast;

  digit_scoreboard sb = new();
  bit              random_started = 1'b0;
  int              burst_left = 1;

  binary_to_decimal_ascii dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // offer one number from a falling edge until the transaction completes,
  // returns at the following falling edge
  task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
    s_tvalid = 1'b1;
    s_tdata  = IN_DATA_W'(value);
    do @(posedge clk); while (!s_tready);
    sb.note_value(value);
    @(negedge clk);
  endtask

  // end of burst: drop valid for a random gap with junk on the data lines
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap      = $urandom_range(1, 150);
      s_tvalid = 1'b0;
      s_tdata  = {$urandom, $urandom};
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
  endtask

  function automatic logic [VALUE_WIDTH-1:0] power_of_ten(int exponent);
    logic [VALUE_WIDTH-1:0] p;
    p = 1;
    for (int i = 0; i < exponent; i++) p = p * 10;
    return p;
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] random_value();
    logic [VALUE_WIDTH-1:0] v;
    int                     width;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ;
      4, 5, 6: begin
        width = $urandom_range(1, VALUE_WIDTH);
        v     = v & ({VALUE_WIDTH{1'b1}} >> (VALUE_WIDTH - width));
      end
      7: v = power_of_ten($urandom_range(0, 19)) + VALUE_WIDTH'($urandom_range(0, 2)) - 1;
      8: v = VALUE_WIDTH'($urandom_range(0, 1000));
      default: v = {VALUE_WIDTH{1'b1}} - VALUE_WIDTH'($urandom_range(0, 3));
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_digit(m_tdata, m_tlast);
  end

  initial begin : receiver
    int mode;
    int phase_len;
    int period;
    bit held;
    held = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      // one long hold-off so the block backs up into its input
      if (random_started && !held) begin
        held     = 1'b1;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode      = $urandom_range(RX_OPEN, RX_PERIODIC);
      phase_len = $urandom_range(50, 400);
      period    = $urandom_range(2, 8);
      for (int n = 0; n < phase_len; n++) begin
        case (mode)
          RX_OPEN:   m_tready = 1'b1;
          RX_COIN:   m_tready = 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
          default:   m_tready = ((n % period) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [VALUE_WIDTH-1:0] directed[$];
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    directed = '{
      64'd0, 64'd1, 64'd9, 64'd10, 64'd11, 64'd99, 64'd100, 64'd999, 64'd1000,
      64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000,
      64'd1000000000000000000, 64'd9999999999999999999, 64'd10000000000000000000,
      64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF,
      64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0123_4567_89AB_CDEF,
      64'd100000, 64'd1010101
    };
    foreach (directed[i]) begin
      send_value(directed[i]);
      pace_sender();
    end

    random_started = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_value(random_value());
      pace_sender();
    end
    s_tvalid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
